FILE: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define SP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define SP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/sp2c_pkg.sv
package sp2c_pkg;

  // fraction bits of the x/y datapath
  localparam int FRAC_BITS = 16;
  // angle resolution inside the rotator: 2^32 units per turn
  localparam int TURN_BITS = 32;
  // angle accumulator width, one extra bit for the sign
  localparam int ZW = TURN_BITS + 1;
  // arctangent table depth
  localparam int ATAN_ENTRIES = 24;

  // CORDIC gain compensation, 2^30 scale
  localparam int GAIN_BITS = 30;
  localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'd652032874;

  // configuration register indexes
  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_START_ANGLE = 2'd0;
  localparam cfg_addr_t CFG_ANGLE_STEP  = 2'd1;
  localparam cfg_addr_t CFG_MAX_RANGE   = 2'd2;

  // arctan(2^-i) in 2^32 units per turn, rounded to nearest
  function automatic logic [TURN_BITS-1:0] atan_turn32(input int unsigned i);
    logic [TURN_BITS-1:0] a;
    unique case (i)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: design/sp2c_prep.sv
// Front stage: range filter, beam angle, gain-scaled start vector.
module sp2c_prep #(
  parameter int INDEX_BITS = 12,
  parameter int RANGE_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [RANGE_BITS-1:0]                  in_range,
  input  logic                                   in_finite,
  input  logic [INDEX_BITS-1:0]                  in_index,
  input  logic [ANGLE_BITS-1:0]                  start_angle,
  input  logic [ANGLE_BITS-1:0]                  angle_step,
  input  logic [RANGE_BITS-1:0]                  max_range,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [RANGE_BITS+sp2c_pkg::FRAC_BITS+1:0] out_x,
  output logic signed [RANGE_BITS+sp2c_pkg::FRAC_BITS+1:0] out_y,
  output logic signed [sp2c_pkg::ZW-1:0]         out_z,
  output logic [1:0]                             out_quad,
  output logic [INDEX_BITS-1:0]                  out_index
);

  localparam int XW   = RANGE_BITS + sp2c_pkg::FRAC_BITS + 2;
  localparam int X0W  = RANGE_BITS + sp2c_pkg::FRAC_BITS;
  localparam int GPW  = RANGE_BITS + sp2c_pkg::GAIN_BITS;
  localparam int GSH  = sp2c_pkg::GAIN_BITS - sp2c_pkg::FRAC_BITS;
  localparam int SPW  = ANGLE_BITS + INDEX_BITS;
  localparam int PADW = sp2c_pkg::TURN_BITS - ANGLE_BITS;

  logic                      keep;
  logic [GPW-1:0]            gain_prod;
  logic [GPW-1:0]            gain_rnd;
  logic [SPW-1:0]            step_prod;
  logic [ANGLE_BITS-1:0]     ang;
  logic signed [XW-1:0]      x_nxt;
  logic signed [sp2c_pkg::ZW-1:0] z_nxt;

  logic                      valid_r;
  logic signed [XW-1:0]      x_r;
  logic signed [sp2c_pkg::ZW-1:0] z_r;
  logic [1:0]                quad_r;
  logic [INDEX_BITS-1:0]     index_r;

  // drop beams that are not finite or lie beyond the limit
  assign keep = in_finite && (in_range <= max_range);

  // start vector: round(range * G * 2^16)
  assign gain_prod = GPW'(in_range) * GPW'(sp2c_pkg::GAIN_Q30);
  assign gain_rnd  = gain_prod + (GPW'(1) << (GSH - 1));
  assign x_nxt     = XW'(X0W'(gain_rnd >> GSH));

  // beam angle wraps modulo one turn
  assign step_prod = SPW'(angle_step) * SPW'(in_index);
  assign ang       = start_angle + step_prod[ANGLE_BITS-1:0];
  assign z_nxt     = sp2c_pkg::ZW'({ang[ANGLE_BITS-3:0], {PADW{1'b0}}});

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x_r     <= x_nxt;
      z_r     <= z_nxt;
      quad_r  <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
      index_r <= in_index;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = '0;
  assign out_z     = z_r;
  assign out_quad  = quad_r;
  assign out_index = index_r;

endmodule

FILE: design/sp2c_cordic_stage.sv
// One CORDIC rotation step with its own pipeline register.
module sp2c_cordic_stage #(
  parameter int INDEX_BITS = 12,
  parameter int RANGE_BITS = 16,
  parameter int STAGE      = 0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [RANGE_BITS+sp2c_pkg::FRAC_BITS+1:0] in_x,
  input  logic signed [RANGE_BITS+sp2c_pkg::FRAC_BITS+1:0] in_y,
  input  logic signed [sp2c_pkg::ZW-1:0]         in_z,
  input  logic [1:0]                             in_quad,
  input  logic [INDEX_BITS-1:0]                  in_index,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [RANGE_BITS+sp2c_pkg::FRAC_BITS+1:0] out_x,
  output logic signed [RANGE_BITS+sp2c_pkg::FRAC_BITS+1:0] out_y,
  output logic signed [sp2c_pkg::ZW-1:0]         out_z,
  output logic [1:0]                             out_quad,
  output logic [INDEX_BITS-1:0]                  out_index
);

  localparam int XW = RANGE_BITS + sp2c_pkg::FRAC_BITS + 2;
  localparam logic signed [sp2c_pkg::ZW-1:0] ATAN =
    sp2c_pkg::ZW'(sp2c_pkg::atan_turn32(STAGE));

  logic signed [XW-1:0]           dx;
  logic signed [XW-1:0]           dy;
  logic                           rot_pos;
  logic signed [XW-1:0]           x_nxt;
  logic signed [XW-1:0]           y_nxt;
  logic signed [sp2c_pkg::ZW-1:0] z_nxt;

  logic                           valid_r;
  logic signed [XW-1:0]           x_r;
  logic signed [XW-1:0]           y_r;
  logic signed [sp2c_pkg::ZW-1:0] z_r;
  logic [1:0]                     quad_r;
  logic [INDEX_BITS-1:0]          index_r;

  // shifts floor toward minus infinity
  assign dx      = in_y >>> STAGE;
  assign dy      = in_x >>> STAGE;
  assign rot_pos = !in_z[sp2c_pkg::ZW-1];

  assign x_nxt = rot_pos ? (in_x - dx)   : (in_x + dx);
  assign y_nxt = rot_pos ? (in_y + dy)   : (in_y - dy);
  assign z_nxt = rot_pos ? (in_z - ATAN) : (in_z + ATAN);

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      quad_r  <= in_quad;
      index_r <= in_index;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_quad  = quad_r;
  assign out_index = index_r;

endmodule

FILE: design/sp2c_finish.sv
// Back stage: quadrant rotation, rounding, saturation, output register.
module sp2c_finish #(
  parameter int INDEX_BITS = 12,
  parameter int RANGE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [RANGE_BITS+sp2c_pkg::FRAC_BITS+1:0] in_x,
  input  logic signed [RANGE_BITS+sp2c_pkg::FRAC_BITS+1:0] in_y,
  input  logic [1:0]                             in_quad,
  input  logic [INDEX_BITS-1:0]                  in_index,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [RANGE_BITS:0]             out_x,
  output logic signed [RANGE_BITS:0]             out_y,
  output logic [INDEX_BITS-1:0]                  out_index
);

  localparam int XW = RANGE_BITS + sp2c_pkg::FRAC_BITS + 2;
  localparam int RW = RANGE_BITS + 2;
  localparam logic signed [RW-1:0] LIM = RW'((64'd1 << RANGE_BITS) - 64'd1);
  localparam logic signed [XW-1:0] HALF = XW'(64'd1 << (sp2c_pkg::FRAC_BITS - 1));

  logic signed [XW-1:0]       xr;
  logic signed [XW-1:0]       yr;
  logic signed [XW-1:0]       xh;
  logic signed [XW-1:0]       yh;
  logic signed [XW-1:0]       xs;
  logic signed [XW-1:0]       ys;
  logic signed [RW-1:0]       xq;
  logic signed [RW-1:0]       yq;
  logic signed [RANGE_BITS:0] x_nxt;
  logic signed [RANGE_BITS:0] y_nxt;

  logic                       valid_r;
  logic signed [RANGE_BITS:0] x_r;
  logic signed [RANGE_BITS:0] y_r;
  logic [INDEX_BITS-1:0]      index_r;

  // exact rotation by the quadrant's multiple of a quarter turn
  always_comb begin
    unique case (in_quad)
      2'd1:    begin xr = -in_y; yr = in_x;  end
      2'd2:    begin xr = -in_x; yr = -in_y; end
      2'd3:    begin xr = in_y;  yr = -in_x; end
      default: begin xr = in_x;  yr = in_y;  end
    endcase
  end

  // round half up to whole millimetres
  assign xh = xr + HALF;
  assign yh = yr + HALF;
  assign xs = xh >>> sp2c_pkg::FRAC_BITS;
  assign ys = yh >>> sp2c_pkg::FRAC_BITS;
  assign xq = xs[RW-1:0];
  assign yq = ys[RW-1:0];

  // clamp rounding overshoot
  always_comb begin
    priority if (xq > LIM)   x_nxt = (RANGE_BITS+1)'(LIM);
    else if (xq < -LIM)      x_nxt = (RANGE_BITS+1)'(-LIM);
    else                     x_nxt = xq[RANGE_BITS:0];
    priority if (yq > LIM)   y_nxt = (RANGE_BITS+1)'(LIM);
    else if (yq < -LIM)      y_nxt = (RANGE_BITS+1)'(-LIM);
    else                     y_nxt = yq[RANGE_BITS:0];
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      index_r <= in_index;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_index = index_r;

endmodule

FILE: design/scan_polar_to_cartesian_unit.sv
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   range_mm, range_finite, beam_index
// out_      output     out_valid / out_stall x_mm, y_mm, point_index
// cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// One word enters per cycle while in_stall is low; it passes the front stage,
// one register per rotation step (CORDIC_STAGES, capped at ATAN_ENTRIES) and the rounding/output stage.
// Dropped beams leave a bubble and produce no output word.
// rst_n is synchronous: it empties the pipeline and restores the configuration registers.
// Each stage holds its word while the one after it is full and stalled; a
// stage that is empty keeps accepting, so bubbles are squeezed out.
module scan_polar_to_cartesian_unit #(
  parameter int INDEX_BITS    = 12,
  parameter int RANGE_BITS    = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [RANGE_BITS-1:0]         in_range_mm,
  input  logic                          in_range_finite,
  input  logic [INDEX_BITS-1:0]         in_beam_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [RANGE_BITS:0]    out_x_mm,
  output logic signed [RANGE_BITS:0]    out_y_mm,
  output logic [INDEX_BITS-1:0]         out_point_index,
  input  logic                          cfg_we,
  input  sp2c_pkg::cfg_addr_t           cfg_index,
  input  logic [((ANGLE_BITS > RANGE_BITS) ? ANGLE_BITS : RANGE_BITS)-1:0] cfg_wdata
);

  localparam int XW = RANGE_BITS + sp2c_pkg::FRAC_BITS + 2;
  localparam int NS = (CORDIC_STAGES < sp2c_pkg::ATAN_ENTRIES) ?
                      CORDIC_STAGES : sp2c_pkg::ATAN_ENTRIES;

  logic [ANGLE_BITS-1:0] start_angle_r;
  logic [ANGLE_BITS-1:0] angle_step_r;
  logic [RANGE_BITS-1:0] max_range_r;

  logic                           st_valid [0:NS];
  logic                           st_ready [0:NS];
  logic signed [XW-1:0]           st_x     [0:NS];
  logic signed [XW-1:0]           st_y     [0:NS];
  logic signed [sp2c_pkg::ZW-1:0] st_z     [0:NS];
  logic [1:0]                     st_quad  [0:NS];
  logic [INDEX_BITS-1:0]          st_index [0:NS];
  logic                           prep_ready;
  logic                           fin_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      max_range_r   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sp2c_pkg::CFG_START_ANGLE: start_angle_r <= cfg_wdata[ANGLE_BITS-1:0];
        sp2c_pkg::CFG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[ANGLE_BITS-1:0];
        sp2c_pkg::CFG_MAX_RANGE:   max_range_r   <= cfg_wdata[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // filter, angle and start vector
  sp2c_prep #(
    .INDEX_BITS(INDEX_BITS),
    .RANGE_BITS(RANGE_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (prep_ready),
    .in_range    (in_range_mm),
    .in_finite   (in_range_finite),
    .in_index    (in_beam_index),
    .start_angle (start_angle_r),
    .angle_step  (angle_step_r),
    .max_range   (max_range_r),
    .out_valid   (st_valid[0]),
    .out_ready   (st_ready[0]),
    .out_x       (st_x[0]),
    .out_y       (st_y[0]),
    .out_z       (st_z[0]),
    .out_quad    (st_quad[0]),
    .out_index   (st_index[0])
  );

  assign in_stall = !prep_ready;

  // rotation pipeline
  for (genvar k = 0; k < NS; k++) begin : g_rot
    sp2c_cordic_stage #(
      .INDEX_BITS(INDEX_BITS),
      .RANGE_BITS(RANGE_BITS),
      .STAGE     (k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_x      (st_x[k]),
      .in_y      (st_y[k]),
      .in_z      (st_z[k]),
      .in_quad   (st_quad[k]),
      .in_index  (st_index[k]),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .out_x     (st_x[k+1]),
      .out_y     (st_y[k+1]),
      .out_z     (st_z[k+1]),
      .out_quad  (st_quad[k+1]),
      .out_index (st_index[k+1])
    );
  end

  assign st_ready[NS] = fin_ready;

  // quadrant, rounding and output word
  sp2c_finish #(
    .INDEX_BITS(INDEX_BITS),
    .RANGE_BITS(RANGE_BITS)
  ) u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (st_valid[NS]),
    .in_ready  (fin_ready),
    .in_x      (st_x[NS]),
    .in_y      (st_y[NS]),
    .in_quad   (st_quad[NS]),
    .in_index  (st_index[NS]),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_x     (out_x_mm),
    .out_y     (out_y_mm),
    .out_index (out_point_index)
  );

endmodule

FILE: design/sp2c_checker.sv
`include "assert_macros.svh"

// Port-level checks on the converter.
module sp2c_checker #(
  parameter int INDEX_BITS = 12,
  parameter int RANGE_BITS = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [RANGE_BITS:0] out_x_mm,
  input logic signed [RANGE_BITS:0] out_y_mm,
  input logic [INDEX_BITS-1:0]      out_point_index
);

  localparam logic [RANGE_BITS:0] MOST_NEG = {1'b1, {RANGE_BITS{1'b0}}};

  // a held output word keeps its payload
  `SP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_x_mm) && $stable(out_y_mm) && $stable(out_point_index), "output word changed while stalled")

  // input backs up only when the output word is stuck
  `SP_ASSERT_ALWAYS(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with room in pipeline")

  // saturation keeps coordinates symmetric
  `SP_ASSERT(a_x_sat, out_valid |-> out_x_mm != MOST_NEG, "x_mm outside saturation range")
  `SP_ASSERT(a_y_sat, out_valid |-> out_y_mm != MOST_NEG, "y_mm outside saturation range")

  // an empty output stage never turns an offered word away
  `SP_ASSERT(a_idle_in, in_valid && !out_valid |-> !in_stall, "pipeline blocked with empty output")

endmodule

bind scan_polar_to_cartesian_unit sp2c_checker #(
  .INDEX_BITS(INDEX_BITS),
  .RANGE_BITS(RANGE_BITS)
) u_sp2c_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_x_mm        (out_x_mm),
  .out_y_mm        (out_y_mm),
  .out_point_index (out_point_index)
);
